>>> hw/rtl/skrf_pkg.sv
// Shared types and constants for the scalar Kalman rate fusion unit.
package skrf_pkg;

  localparam int unsigned RateW    = 16;  // signed Q6.10 rate
  localparam int unsigned VarW     = 32;  // unsigned Q16.16 variance
  localparam int unsigned DenW     = VarW + 1;
  localparam int unsigned NumW     = 50;  // R*mean + var*gyro
  localparam int unsigned WideW    = 2 * VarW;
  localparam int unsigned SerSteps = VarW;
  localparam int unsigned SerCntW  = $clog2(SerSteps);

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMotionVar = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMeasVar   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInitVar   = 2'd2;

  localparam logic ActGyro = 1'b0;
  localparam logic ActOdom = 1'b1;

  localparam logic [VarW-1:0] MotionVarRst = 32'd262144;   // 4.0
  localparam logic [VarW-1:0] MeasVarRst   = 32'd32768;    // 0.5
  localparam logic [VarW-1:0] InitVarRst   = 32'd65536000; // 1000.0

  typedef struct packed {
    logic                    action;
    logic signed [RateW-1:0] rate_sample;
  } skrf_in_req_t;

  typedef struct packed {
    logic signed [RateW-1:0] filtered_rate;
    logic [VarW-1:0]         estimate_variance;
  } skrf_out_req_t;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;  // high in the cycle of the last step
  } skrf_sts_t;

endpackage

>>> hw/rtl/skrf_mac.sv
// Bit-serial multiplier: R*mean + var*gyro and var*R, one multiplier bit per cycle.
module skrf_mac
  import skrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RateW-1:0]    mean_i,
  input  logic [RateW-1:0]    gyro_i,
  input  logic [VarW-1:0]     var_i,
  input  logic [VarW-1:0]     r_i,
  output skrf_sts_t           sts_o,
  output logic [NumW-1:0]     num_o,
  output logic [WideW-1:0]    prod_o
);

  localparam int unsigned HiW = NumW - VarW;  // signed high part of num
  localparam int unsigned TW  = HiW + 1;

  logic               busy_q, busy_d;
  logic [SerCntW-1:0] cnt_q, cnt_d;
  logic [VarW-1:0]    rx_q, vx_q, vh_q;
  logic [RateW-1:0]   mh_q, gh_q;
  logic [HiW-1:0]     h_q;
  logic [VarW-1:0]    l_q, ph_q, pl_q;
  logic [TW-1:0]      t_sum;
  logic [VarW:0]      p_sum;
  logic               last;

  assign last = (cnt_q == '0);

  always_comb begin
    t_sum = {h_q[HiW-1], h_q}
          + (rx_q[0] ? {{(TW-RateW){mh_q[RateW-1]}}, mh_q} : '0)
          + (vx_q[0] ? {{(TW-RateW){gh_q[RateW-1]}}, gh_q} : '0);
    p_sum = {1'b0, ph_q} + (rx_q[0] ? {1'b0, vh_q} : '0);
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = SerCntW'(SerSteps - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rx_q <= r_i;
      vx_q <= var_i;
      vh_q <= var_i;
      mh_q <= mean_i;
      gh_q <= gyro_i;
      h_q  <= '0;
      l_q  <= '0;
      ph_q <= '0;
      pl_q <= '0;
    end else if (busy_q) begin
      rx_q <= {1'b0, rx_q[VarW-1:1]};
      vx_q <= {1'b0, vx_q[VarW-1:1]};
      h_q  <= t_sum[TW-1:1];
      l_q  <= {t_sum[0], l_q[VarW-1:1]};
      ph_q <= p_sum[VarW:1];
      pl_q <= {p_sum[0], pl_q[VarW-1:1]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q & last;
  assign num_o      = {h_q, l_q};
  assign prod_o     = {ph_q, pl_q};

endmodule

>>> hw/rtl/skrf_div.sv
// Restoring divider, one quotient bit per cycle; flags quotients of 2^32 and above.
module skrf_div
  import skrf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WideW-1:0]  dividend_i,
  input  logic [DenW-1:0]   divisor_i,   // held by the caller while busy
  output skrf_sts_t         sts_o,
  output logic [VarW-1:0]   quotient_o,
  output logic              ovf_o
);

  logic               busy_q, busy_d;
  logic [SerCntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0]    rem_q;
  logic [VarW-1:0]    quo_q;
  logic               ovf_q;
  logic [DenW:0]      trial;
  logic [DenW+1:0]    diff;
  logic               ge;
  logic               last;

  assign last  = (cnt_q == '0);
  assign trial = {rem_q, quo_q[VarW-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_i};
  assign ge    = ~diff[DenW+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = SerCntW'(SerSteps - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // upper half below the divisor means the quotient fits in 32 bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ({1'b0, dividend_i[WideW-1:VarW]} >= divisor_i);
      rem_q <= {1'b0, dividend_i[WideW-1:VarW]};
      quo_q <= dividend_i[VarW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_q <= {quo_q[VarW-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q & last;
  assign quotient_o = quo_q;
  assign ovf_o      = ovf_q;

endmodule

>>> hw/rtl/scalar_kalman_rate_fusion_unit.sv
// Top level of the scalar Kalman rate fusion unit: control, state and ports.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_req_i  (action, rate)
//   out     | output    | out_valid_o / out_stall_i  | out_req_o (rate, var)
//   cfg     | input     | cfg_we_i, cfg_idx_i        | cfg_wdata_i
//
// Gyro and seeding odometry requests never stall the input. A later odometry
// request stalls it after its accept through launch, 32-step bit-serial multiply,
// set-up states ABS, RND and DSTART, 32-step divider pair and final state (both
// passes skipped when both variances are zero), so no request is taken until it
// is done. Reset is asynchronous; the variance reloads its 1000.0 reset value.
// Requests are taken while a result waits in the output register; a finished
// computation holds in its final cycle until that register frees.
module scalar_kalman_rate_fusion_unit
  import skrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skrf_in_req_t        in_req_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skrf_out_req_t       out_req_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [VarW-1:0]     cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;  // zero check, launch multiply
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ABS    = 3'd3;  // sign and magnitude of numerator
  localparam logic [2:0] ST_RND    = 3'd4;  // add half divisor for rounding
  localparam logic [2:0] ST_DSTART = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;  // saturate, commit, load output

  localparam int unsigned SumW = RateW + 2;

  logic [2:0]       state_q, state_d;

  // configuration
  logic [VarW-1:0]  mv_q, r_q;

  // filter state
  logic [RateW-1:0] mean_q, mean_d;
  logic [VarW-1:0]  var_q, var_d;
  logic [RateW-1:0] prev_q, prev_d;
  logic [RateW-1:0] gyro_q, gyro_d;
  logic             first_q, first_d;

  // working registers
  logic [DenW-1:0]  den_q, den_d;
  logic             skip_q, skip_d;
  logic             neg_q, neg_d;
  logic [NumW-1:0]  mag_q, mag_d;
  logic [WideW-1:0] dnum_q, dnum_d, dprd_q, dprd_d;

  // output register
  logic             out_valid_q, out_valid_d;
  skrf_out_req_t    out_req_q, out_req_d;

  logic             accept, out_free;
  logic             mac_start, div_start;
  skrf_sts_t        mac_sts, divm_sts, divv_sts;
  logic [NumW-1:0]  mac_num;
  logic [WideW-1:0] mac_prod;
  logic [VarW-1:0]  qm, qv;
  logic             ovf_m, ovf_v;

  logic [SumW-1:0]  pred_sum;
  logic [RateW-1:0] pred_mean;
  logic [VarW:0]    pred_var_sum;
  logic [VarW-1:0]  pred_var;
  logic             qm_big;
  logic [RateW-1:0] upd_mean;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // prediction: mean += rate - previous odometry rate, var += motion variance
  always_comb begin
    pred_sum = {{2{mean_q[RateW-1]}}, mean_q}
             + {{2{in_req_i.rate_sample[RateW-1]}}, in_req_i.rate_sample}
             - {{2{prev_q[RateW-1]}}, prev_q};
    if (!pred_sum[SumW-1] && (pred_sum[SumW-2:RateW-1] != 2'b00)) begin
      pred_mean = {1'b0, {(RateW-1){1'b1}}};
    end else if (pred_sum[SumW-1] && (pred_sum[SumW-2:RateW-1] != 2'b11)) begin
      pred_mean = {1'b1, {(RateW-1){1'b0}}};
    end else begin
      pred_mean = pred_sum[RateW-1:0];
    end
    pred_var_sum = {1'b0, var_q} + {1'b0, mv_q};
    pred_var     = pred_var_sum[VarW] ? '1 : pred_var_sum[VarW-1:0];
  end

  // rounded mean quotient back to a saturated signed rate
  always_comb begin
    qm_big = ovf_m | (|qm[VarW-1:RateW]);
    if (!neg_q) begin
      upd_mean = (qm_big | qm[RateW-1]) ? {1'b0, {(RateW-1){1'b1}}} : qm[RateW-1:0];
    end else if (qm_big | (qm[RateW-1] & (|qm[RateW-2:0]))) begin
      upd_mean = {1'b1, {(RateW-1){1'b0}}};
    end else begin
      upd_mean = RateW'(0) - qm[RateW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    mean_d      = mean_q;
    var_d       = var_q;
    prev_d      = prev_q;
    gyro_d      = gyro_q;
    first_d     = first_q;
    den_d       = den_q;
    skip_d      = skip_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    dnum_d      = dnum_q;
    dprd_d      = dprd_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_req_d   = out_req_q;
    mac_start   = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.action == ActGyro) begin
            gyro_d = in_req_i.rate_sample;
          end else if (first_q) begin
            // first odometry sample seeds the filter, no result
            mean_d  = in_req_i.rate_sample;
            prev_d  = in_req_i.rate_sample;
            first_d = 1'b0;
          end else begin
            mean_d  = pred_mean;
            var_d   = pred_var;
            prev_d  = in_req_i.rate_sample;
            state_d = ST_MSTART;
          end
        end
      end
      ST_MSTART: begin
        den_d = {1'b0, var_q} + {1'b0, r_q};
        // both variances zero: keep the predicted mean, variance stays zero
        skip_d = (var_q == '0) && (r_q == '0);
        if ((var_q == '0) && (r_q == '0)) begin
          state_d = ST_FIN;
        end else begin
          mac_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mac_sts.done) state_d = ST_ABS;
      end
      ST_ABS: begin
        neg_d   = mac_num[NumW-1];
        mag_d   = mac_num[NumW-1] ? (NumW'(0) - mac_num) : mac_num;
        state_d = ST_RND;
      end
      ST_RND: begin
        dnum_d  = {{(WideW-NumW){1'b0}}, mag_q} + {{(WideW-VarW){1'b0}}, den_q[DenW-1:1]};
        dprd_d  = mac_prod + {{(WideW-VarW){1'b0}}, den_q[DenW-1:1]};
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (divm_sts.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          if (!skip_q) begin
            mean_d = upd_mean;
            var_d  = qv;
          end
          out_valid_d                 = 1'b1;
          out_req_d.filtered_rate     = skip_q ? mean_q : upd_mean;
          out_req_d.estimate_variance = skip_q ? var_q : qv;
          state_d                     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mv_q        <= MotionVarRst;
      r_q         <= MeasVarRst;
      mean_q      <= '0;
      var_q       <= InitVarRst;
      prev_q      <= '0;
      gyro_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mean_q      <= mean_d;
      var_q       <= var_d;
      prev_q      <= prev_d;
      gyro_q      <= gyro_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMotionVar: mv_q <= cfg_wdata_i;
          CfgMeasVar:   r_q  <= cfg_wdata_i;
          // initial variance only matters at reset, which restores its
          // default, so the write has no lasting effect
          CfgInitVar:   ;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    den_q     <= den_d;
    skip_q    <= skip_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    dnum_q    <= dnum_d;
    dprd_q    <= dprd_d;
    out_req_q <= out_req_d;
  end

  skrf_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .mean_i  (mean_q),
    .gyro_i  (gyro_q),
    .var_i   (var_q),
    .r_i     (r_q),
    .sts_o   (mac_sts),
    .num_o   (mac_num),
    .prod_o  (mac_prod)
  );

  // mean: (|num| + den/2) / den
  skrf_div u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dnum_q),
    .divisor_i  (den_q),
    .sts_o      (divm_sts),
    .quotient_o (qm),
    .ovf_o      (ovf_m)
  );

  // variance: (var*R + den/2) / den, always below 2^32
  skrf_div u_div_var (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dprd_q),
    .divisor_i  (den_q),
    .sts_o      (divv_sts),
    .quotient_o (qv),
    .ovf_o      (ovf_v)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // multiply and divide passes never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_sts.busy && (divm_sts.busy || divv_sts.busy)))
    else $error("multiplier and dividers busy together");

  // the two dividers run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (divm_sts.busy == divv_sts.busy) && (divm_sts.done == divv_sts.done))
    else $error("dividers out of step");

  // updated variance never exceeds the measurement variance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !skip_q) |-> (!ovf_v && qv <= r_q))
    else $error("variance update out of range");

  // no result before the filter has been seeded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !first_q)
    else $error("result before first odometry sample");

endmodule

>>> tb/sv/scalar_kalman_rate_fusion_unit_tb.sv
// Testbench for the scalar Kalman rate fusion unit: self-checking against a built-in predictor.
module scalar_kalman_rate_fusion_unit_tb
  import skrf_pkg::*;
();

  // Scoreboard: keeps its own copy of the filter state and the registers, works out
  // the fused rate for each accepted odometry request and checks DUT results in order.
  class rate_fusion_scoreboard;
    logic [VarW-1:0]         motion_var;
    logic [VarW-1:0]         meas_var;
    logic [VarW-1:0]         init_var;
    logic signed [RateW-1:0] mean;
    logic signed [RateW-1:0] prev_odom;
    logic signed [RateW-1:0] gyro_rate;
    logic [VarW-1:0]         est_var;
    logic                    awaiting_seed;
    skrf_out_req_t           expected_estimates[$];
    int unsigned             mismatch_count;

    function new();
      motion_var     = MotionVarRst;
      meas_var       = MeasVarRst;
      init_var       = InitVarRst;
      mean           = '0;
      prev_odom      = '0;
      gyro_rate      = '0;
      est_var        = InitVarRst;
      awaiting_seed  = 1'b1;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [VarW-1:0] val);
      case (idx)
        CfgMotionVar: motion_var = val;
        CfgMeasVar:   meas_var   = val;
        CfgInitVar:   init_var   = val;  // stored but never used; the DUT ignores this write
        default: ;
      endcase
    endfunction

    function logic signed [RateW-1:0] clamp_rate(longint v);
      if (v > 32767)  return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[RateW-1:0];
    endfunction

    // Note an accepted request; odometry after the seed yields one expected estimate.
    function void take_sample(skrf_in_req_t req);
      logic signed [RateW-1:0] rate;
      longint                  motion;
      longint                  num;
      logic [63:0]             pred;
      logic [63:0]             den;
      logic [63:0]             mag;
      logic [63:0]             quo;
      logic [63:0]             prod;
      skrf_out_req_t           est;
      rate = req.rate_sample;
      if (req.action == ActGyro) begin
        gyro_rate = rate;
        return;
      end
      if (awaiting_seed) begin
        mean          = rate;
        prev_odom     = rate;
        awaiting_seed = 1'b0;
        return;
      end
      // prediction
      motion    = longint'(rate) - longint'(prev_odom);
      pred      = 64'(est_var) + 64'(motion_var);
      mean      = clamp_rate(longint'(mean) + motion);
      est_var   = (pred > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pred[VarW-1:0];
      prev_odom = rate;
      // measurement update, rounded to nearest, ties away from zero
      den = 64'(est_var) + 64'(meas_var);
      if (den != 0) begin
        num  = longint'(meas_var) * longint'(mean) + longint'(est_var) * longint'(gyro_rate);
        prod = 64'(est_var) * 64'(meas_var);
        mag  = (num < 0) ? 64'(-num) : 64'(num);
        quo  = (mag + den / 2) / den;
        mean = clamp_rate((num < 0) ? -longint'(quo) : longint'(quo));
        est_var = 32'((prod + den / 2) / den);
      end
      est.filtered_rate     = mean;
      est.estimate_variance = est_var;
      expected_estimates.push_back(est);
    endfunction

    function void log_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%t: %s", $realtime, what);
    endfunction

    function void check_estimate(skrf_out_req_t got);
      skrf_out_req_t want;
      if (expected_estimates.size() == 0) begin
        log_mismatch($sformatf("unexpected result rate %0d var %08h",
                               got.filtered_rate, got.estimate_variance));
        return;
      end
      want = expected_estimates.pop_front();
      if (got.filtered_rate !== want.filtered_rate ||
          got.estimate_variance !== want.estimate_variance)
        log_mismatch($sformatf("rate exp %0d got %0d, var exp %08h got %08h",
                               want.filtered_rate, got.filtered_rate,
                               want.estimate_variance, got.estimate_variance));
    endfunction
  endclass

  localparam logic signed [RateW-1:0] RateMax = 16'sh7FFF;
  localparam logic signed [RateW-1:0] RateMin = 16'sh8000;
  // Settling waits a margin past the longest odometry computation.
  localparam int unsigned SettleCycles = 100;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  skrf_in_req_t        in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  skrf_out_req_t       out_req_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [VarW-1:0]     cfg_wdata_i;

  rate_fusion_scoreboard fusion_sb;
  bit                    quiet;       // phase with no gaps and no stalls
  int unsigned           stall_left;

  scalar_kalman_rate_fusion_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 15);
    if (r < 9)  return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Rates lean toward the extremes so the mean saturation paths get hit often.
  function automatic logic signed [RateW-1:0] pick_rate();
    case ($urandom_range(0, 15))
      0:       return RateMax;
      1:       return RateMin;
      2:       return '0;
      3:       return RateW'($signed($urandom_range(0, 128)) - 64);
      default: return RateW'($urandom);
    endcase
  endfunction

  function automatic logic [VarW-1:0] pick_variance();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_request(logic act, logic signed [RateW-1:0] rate);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i.action      = act;
    in_req_i.rate_sample = rate;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    fusion_sb.take_sample(in_req_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [VarW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    fusion_sb.set_register(idx, val);
  endtask

  task automatic apply_settings(logic [VarW-1:0] motion, logic [VarW-1:0] meas,
                                logic [VarW-1:0] init);
    write_register(CfgMotionVar, motion);
    write_register(CfgMeasVar, meas);
    write_register(CfgInitVar, init);
  endtask

  // Block goes idle: all estimates back, then enough cycles for any trailing work.
  task automatic settle();
    in_valid_i = 1'b0;
    while (fusion_sb.expected_estimates.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Mostly odometry so that results keep flowing, gyro updates mixed in.
  task automatic run_random(int unsigned count);
    repeat (count)
      send_request(($urandom_range(0, 7) < 5) ? ActOdom : ActGyro, pick_rate());
  endtask

  // Result side: random stall stretches, changed at the falling edge only.
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_stall_i = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Accepted results are checked at the rising edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) fusion_sb.check_estimate(out_req_o);
    end
  end

  initial begin
    logic [VarW-1:0] meas;
    fusion_sb   = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgMotionVar;
    cfg_wdata_i = '0;
    quiet       = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part on reset settings: gyro extremes, the seeding odometry request,
    // full-scale odometry swings that saturate the predicted mean both ways.
    send_request(ActGyro, RateMax);
    send_request(ActGyro, RateMin);
    send_request(ActOdom, '0);        // seeds mean, no result
    send_request(ActOdom, '0);        // pulled toward the minimum gyro
    send_request(ActGyro, RateMax);
    send_request(ActOdom, RateMin);
    send_request(ActOdom, RateMax);   // motion +65535
    send_request(ActGyro, RateMin);
    send_request(ActOdom, RateMin);   // motion -65535
    send_request(ActGyro, '0);
    send_request(ActOdom, 16'sd1);
    send_request(ActOdom, -16'sd1);
    send_request(ActOdom, '0);
    send_request(ActGyro, 16'sd1);
    send_request(ActGyro, -16'sd1);
    send_request(ActOdom, RateMax);
    send_request(ActOdom, RateMax);   // zero motion
    send_request(ActOdom, 16'sh5555);
    send_request(ActOdom, 16'shAAAA);
    settle();

    // Random phases, each behind its own register settings.
    for (int phase = 1; phase <= 11; phase++) begin
      case (phase)
        1: apply_settings('0, 32'd1, '0);               // smallest noise
        2: apply_settings('1, '1, '1);                  // variance saturates
        3: apply_settings('1, 32'd1, pick_variance());
        4: apply_settings('0, '1, pick_variance());
        5: apply_settings(MotionVarRst, MeasVarRst, InitVarRst);
        default: begin
          meas = pick_variance();
          if (meas == 0) meas = 32'd1;                  // measurement noise is never zero
          apply_settings(pick_variance(), meas, pick_variance());
        end
      endcase
      quiet = (phase % 4 == 3);
      run_random(140);
      settle();
    end
    quiet = 1'b0;

    if (fusion_sb.mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
